### src/test_pattern_pixel_color_core_defines.svh
// Assertion macros for the grid test-pattern core.
`ifndef TEST_PATTERN_PIXEL_COLOR_CORE_DEFINES_SVH
`define TEST_PATTERN_PIXEL_COLOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TPPC_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("test pattern core: property violated");

// Next-cycle implication.
`define TPPC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("test pattern core: property violated");

`else

`define TPPC_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define TPPC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

### src/tppc_pkg.sv
`default_nettype none

package tppc_pkg;

  localparam int COORD_BITS   = 12;
  localparam int CELL_W       = 8;
  localparam int STEP_W       = 8;
  localparam int COLOR_W      = 32;
  localparam int LAYOUT_W     = 30;
  localparam int GROUP_W      = 10;
  localparam int NUM_COMP     = 3;
  localparam int POS_W        = 5;
  localparam int FIELD_W      = 8;
  localparam int BPP_W        = 6;
  localparam int BYTES_W      = 4;
  localparam int OFFSET_W     = 26;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int LIN_W        = 2 * COORD_BITS + 1;
  localparam int IDX_W        = 2 * CELL_W;
  localparam int PROD_W       = IDX_W + STEP_W;
  localparam int DIV_CNT_W    = $clog2(COORD_BITS + 1);
  localparam int IN_TDATA_W   = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = COLOR_W + 2 + OFFSET_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_COUNT     = 3'd0,
    REG_FIRST_COLOR    = 3'd1,
    REG_COLOR_STEP     = 3'd2,
    REG_DIRECT_COLOR   = 3'd3,
    REG_COLOR_LAYOUT   = 3'd4,
    REG_PIXEL_DEPTH    = 3'd5,
    REG_HORIZONTAL_RES = 3'd6,
    REG_VERTICAL_RES   = 3'd7
  } cfg_reg_t;

  // Partial remainder and dividend/quotient shift word of a restoring divider
  typedef struct packed {
    logic [COORD_BITS-1:0] rem;
    logic [COORD_BITS-1:0] quo;
  } div_pair_t;

  typedef struct packed {
    div_pair_t          col;
    div_pair_t          row;
    logic               on_screen;
    logic [LIN_W-1:0]   lin;
  } div_stage_t;

  // One quotient bit: dividend bits leave the top of quo, quotient bits enter at the bottom
  function automatic div_pair_t div_step(div_pair_t cur, logic [COORD_BITS-1:0] divisor);
    logic [COORD_BITS:0] trial;
    logic [COORD_BITS:0] diff;
    logic                ge;
    div_pair_t           res;
    trial   = {cur.rem, cur.quo[COORD_BITS-1]};
    diff    = trial - {1'b0, divisor};
    ge      = (trial >= {1'b0, divisor});
    res.rem = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
    res.quo = {cur.quo[COORD_BITS-2:0], ge};
    return res;
  endfunction

  // Mask sizes above eight bits are clamped to eight
  function automatic logic [FIELD_W-1:0] field_mask(logic [POS_W-1:0] size);
    logic [FIELD_W-1:0] m;
    if (size >= POS_W'(FIELD_W)) begin
      m = '1;
    end else begin
      m = ~({FIELD_W{1'b1}} << size);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### src/test_pattern_pixel_color_core.sv
// Channel   Dir  Contents
// s_axis    in   tdata: pixel_x [11:0], pixel_y [23:12]
// m_axis    out  tdata: pixel_color [31:0], pixel_drawn [32], pattern_error [33],
//                       byte_offset [59:34]
// cfg       in   cfg_we, cfg_index (register number), cfg_data
//
// One pixel per clock while the output is not stalled and the cell-size divider is
// not busy; the column and row dividers work one bit per stage.
// After reset and after every register write the input is held off while the
// iterative divider finds cell width/height.
// Reset is synchronous; a stalled output freezes the whole pipeline in place.
`default_nettype none

`include "test_pattern_pixel_color_core_defines.svh"

module test_pattern_pixel_color_core
  import tppc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // pixel_x, pixel_y
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // pixel_color, pixel_drawn, pattern_error, byte_offset
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [CELL_W-1:0]     cell_count;
  logic [COLOR_W-1:0]    first_color;
  logic [STEP_W-1:0]     color_step;
  logic                  direct_color;
  logic [LAYOUT_W-1:0]   color_layout;
  logic [BPP_W-1:0]      pixel_depth;
  logic [COORD_BITS-1:0] horizontal_res;
  logic [COORD_BITS-1:0] vertical_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count     <= CELL_W'(1);
      first_color    <= '0;
      color_step     <= STEP_W'(1);
      direct_color   <= 1'b0;
      color_layout   <= '0;
      pixel_depth    <= BPP_W'(8);
      horizontal_res <= COORD_BITS'(1024);
      vertical_res   <= COORD_BITS'(768);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CELL_COUNT:     cell_count     <= cfg_data[CELL_W-1:0];
        REG_FIRST_COLOR:    first_color    <= cfg_data[COLOR_W-1:0];
        REG_COLOR_STEP:     color_step     <= cfg_data[STEP_W-1:0];
        REG_DIRECT_COLOR:   direct_color   <= cfg_data[0];
        REG_COLOR_LAYOUT:   color_layout   <= cfg_data[LAYOUT_W-1:0];
        REG_PIXEL_DEPTH:    pixel_depth    <= cfg_data[BPP_W-1:0];
        REG_HORIZONTAL_RES: horizontal_res <= cfg_data[COORD_BITS-1:0];
        REG_VERTICAL_RES:   vertical_res   <= cfg_data[COORD_BITS-1:0];
      endcase
    end
  end

  // Cell size: iterative divide of both resolutions by cell_count
  logic                 busy;
  logic [DIV_CNT_W-1:0] div_cnt;
  div_pair_t            h_div;
  div_pair_t            v_div;
  logic [COORD_BITS-1:0] cell_w;
  logic [COORD_BITS-1:0] cell_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      div_cnt <= '0;
    end else if (cfg_we) begin
      busy    <= 1'b1;
      div_cnt <= '0;
    end else if (busy) begin
      if (div_cnt == DIV_CNT_W'(COORD_BITS)) begin
        busy <= 1'b0;
      end
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      if (div_cnt == '0) begin
        h_div.rem <= '0;
        h_div.quo <= horizontal_res;
        v_div.rem <= '0;
        v_div.quo <= vertical_res;
      end else begin
        h_div <= div_step(h_div, COORD_BITS'(cell_count));
        v_div <= div_step(v_div, COORD_BITS'(cell_count));
      end
    end
  end

  assign cell_w = h_div.quo;
  assign cell_h = v_div.quo;

  // Other derived settings, refreshed every cycle and settled long before busy drops
  logic                  err_r;
  logic [BYTES_W-1:0]    bytes_r;
  logic [COLOR_W-1:0]    bpp_mask;
  logic [FIELD_W-1:0]    comp_base [NUM_COMP];
  logic [FIELD_W-1:0]    comp_mask [NUM_COMP];
  logic [POS_W-1:0]      comp_pos  [NUM_COMP];

  always_ff @(posedge clk) begin
    err_r   <= (cell_count == '0) || (COORD_BITS'(cell_count) > horizontal_res)
               || (COORD_BITS'(cell_count) > vertical_res);
    bytes_r <= BYTES_W'(((BPP_W + 1)'(pixel_depth) + (BPP_W + 1)'(7)) >> 3);
    if (pixel_depth >= BPP_W'(COLOR_W)) begin
      bpp_mask <= '1;
    end else begin
      bpp_mask <= ~({COLOR_W{1'b1}} << pixel_depth);
    end
    for (int c = 0; c < NUM_COMP; c++) begin
      comp_pos[c]  <= color_layout[c*GROUP_W +: POS_W];
      comp_mask[c] <= field_mask(color_layout[c*GROUP_W + POS_W +: POS_W]);
      comp_base[c] <= FIELD_W'(first_color >> color_layout[c*GROUP_W +: POS_W])
                      & field_mask(color_layout[c*GROUP_W + POS_W +: POS_W]);
    end
  end

  // Pipeline control: every stage moves when the output register is free
  logic adv;
  logic a_valid;
  logic [COORD_BITS-1:0] dvalid;
  logic c_valid;
  logic e_valid;
  logic f_valid;
  logic o_valid;

  assign adv           = !o_valid || m_axis_tready;
  assign s_axis_tready = adv && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      dvalid  <= '0;
      c_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s_axis_tvalid && !busy;
      dvalid  <= {dvalid[COORD_BITS-2:0], a_valid};
      c_valid <= dvalid[COORD_BITS-1];
      e_valid <= c_valid;
      f_valid <= e_valid;
      o_valid <= f_valid;
    end
  end

  // Stage A: capture, range check, row base of the offset
  logic [COORD_BITS-1:0]   a_x;
  logic [COORD_BITS-1:0]   a_y;
  logic                    a_in;
  logic [2*COORD_BITS-1:0] a_hy;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x  <= s_axis_tdata[COORD_BITS-1:0];
      a_y  <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      a_in <= (s_axis_tdata[COORD_BITS-1:0] < horizontal_res)
              && (s_axis_tdata[2*COORD_BITS-1:COORD_BITS] < vertical_res);
      a_hy <= (2*COORD_BITS)'(horizontal_res)
              * (2*COORD_BITS)'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
    end
  end

  // Divider stages: column = x / cell_w, row = y / cell_h, one bit per stage
  div_stage_t dstg  [COORD_BITS];
  div_stage_t dsrc  [COORD_BITS];
  div_stage_t dnext [COORD_BITS];

  always_comb begin
    dsrc[0].col.rem   = '0;
    dsrc[0].col.quo   = a_x;
    dsrc[0].row.rem   = '0;
    dsrc[0].row.quo   = a_y;
    dsrc[0].on_screen = a_in;
    dsrc[0].lin       = LIN_W'(a_x) + LIN_W'(a_hy);
    for (int k = 1; k < COORD_BITS; k++) begin
      dsrc[k] = dstg[k-1];
    end
    for (int k = 0; k < COORD_BITS; k++) begin
      dnext[k].col       = div_step(dsrc[k].col, cell_w);
      dnext[k].row       = div_step(dsrc[k].row, cell_h);
      dnext[k].on_screen = dsrc[k].on_screen;
      dnext[k].lin       = dsrc[k].lin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < COORD_BITS; k++) begin
        dstg[k] <= dnext[k];
      end
    end
  end

  // Stage C: grid test, cell products, byte offset
  logic [COORD_BITS-1:0] q_col;
  logic [COORD_BITS-1:0] q_row;
  logic [CELL_W-1:0]     j8;
  logic [CELL_W-1:0]     i8;
  logic [CELL_W-1:0]     ij8;

  assign q_col = dstg[COORD_BITS-1].col.quo;
  assign q_row = dstg[COORD_BITS-1].row.quo;
  assign j8    = q_col[CELL_W-1:0];
  assign i8    = q_row[CELL_W-1:0];
  assign ij8   = i8 + j8;

  logic                c_drawn;
  logic [IDX_W-1:0]    c_in;
  logic [CELL_W-1:0]   c_j8;
  logic [FIELD_W-1:0]  c_delta [NUM_COMP];
  logic [OFFSET_W-1:0] c_offset;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_drawn    <= dstg[COORD_BITS-1].on_screen && !err_r
                    && (q_col < COORD_BITS'(cell_count)) && (q_row < COORD_BITS'(cell_count));
      c_in       <= IDX_W'(i8) * IDX_W'(cell_count);
      c_j8       <= j8;
      // red follows the column, green the row, blue both
      c_delta[0] <= FIELD_W'(j8 * color_step);
      c_delta[1] <= FIELD_W'(i8 * color_step);
      c_delta[2] <= FIELD_W'(ij8 * color_step);
      c_offset   <= OFFSET_W'(dstg[COORD_BITS-1].lin) * OFFSET_W'(bytes_r);
    end
  end

  // Stage E: cell index, wrapped direct components
  logic                e_drawn;
  logic [IDX_W-1:0]    e_idx;
  logic [FIELD_W-1:0]  e_comp [NUM_COMP];
  logic [OFFSET_W-1:0] e_offset;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_drawn  <= c_drawn;
      e_idx    <= c_in + IDX_W'(c_j8);
      for (int c = 0; c < NUM_COMP; c++) begin
        e_comp[c] <= (comp_base[c] + c_delta[c]) & comp_mask[c];
      end
      e_offset <= c_offset;
    end
  end

  // Stage F: indexed product, direct colour assembly
  logic                f_drawn;
  logic [PROD_W-1:0]   f_prod;
  logic [COLOR_W-1:0]  f_direct;
  logic [OFFSET_W-1:0] f_offset;
  logic [COLOR_W-1:0]  direct_word;

  always_comb begin
    direct_word = '0;
    for (int c = 0; c < NUM_COMP; c++) begin
      direct_word = direct_word | (COLOR_W'(e_comp[c]) << comp_pos[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_drawn  <= e_drawn;
      f_prod   <= PROD_W'(e_idx) * PROD_W'(color_step);
      f_direct <= direct_word;
      f_offset <= e_offset;
    end
  end

  // Output register
  logic [COLOR_W-1:0]  o_color;
  logic                o_drawn;
  logic                o_error;
  logic [OFFSET_W-1:0] o_offset;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!f_drawn) begin
        o_color <= '0;
      end else if (direct_color) begin
        o_color <= f_direct;
      end else begin
        o_color <= (first_color + COLOR_W'(f_prod)) & bpp_mask;
      end
      o_drawn  <= f_drawn;
      o_error  <= err_r;
      o_offset <= f_offset;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {OUT_PAD_W'(0), o_offset, o_error, o_drawn, o_color};

  `TPPC_ASSERT_IMPL(a_drawn_no_error, clk, rst, m_axis_tvalid && o_drawn, !o_error)
  `TPPC_ASSERT_IMPL(a_undrawn_black, clk, rst, m_axis_tvalid && !o_drawn, o_color == '0)
  `TPPC_ASSERT_NEXT(a_cfg_holds_input, clk, rst, cfg_we, !s_axis_tready)

endmodule

`default_nettype wire
